[design/oled_text_character_generator_macros.svh]
// Assertion macros for the OLED text character generator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef OLED_TEXT_CHARACTER_GENERATOR_MACROS_SVH
`define OLED_TEXT_CHARACTER_GENERATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define OTCG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define OTCG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/otcg_pkg.sv]
// Shared types, codes and font ROM for the OLED text character generator.
// No dependencies.
package otcg_pkg;

    localparam int DEFAULT_COLUMNS     = 128;
    localparam int DEFAULT_PAGES       = 8;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] GLYPH_BLANK   = 8'h00;

    typedef enum logic [1:0] {
        MODE_CHAR    = 2'd0,
        MODE_NEWLINE = 2'd1,
        MODE_HOME    = 2'd2,
        MODE_SET     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_OPEN = 2'd1,
        KIND_DATA = 2'd2
    } kind_t;

    // job passed from front end to byte sequencer
    typedef struct packed {
        logic        cursor;
        logic        glyph;
        logic [7:0]  col;
        logic [7:0]  line_val;
        logic [39:0] bits;      // column i in bits[8*i +: 8]
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [39:0] font_row(input logic [7:0] code);
        logic [39:0] r;
        case (code)
            8'h20: r = 40'h00_00_00_00_00;
            8'h21: r = 40'h00_00_2F_00_00;
            8'h22: r = 40'h00_07_00_07_00;
            8'h23: r = 40'h14_7F_14_7F_14;
            8'h24: r = 40'h12_2A_7F_2A_24;
            8'h25: r = 40'h62_64_08_13_23;
            8'h26: r = 40'h50_22_55_49_36;
            8'h27: r = 40'h00_00_03_05_00;
            8'h28: r = 40'h00_41_22_1C_00;
            8'h29: r = 40'h00_1C_22_41_00;
            8'h2A: r = 40'h14_08_3E_08_14;
            8'h2B: r = 40'h08_08_3E_08_08;
            8'h2C: r = 40'h00_60_A0_00_00;
            8'h2D: r = 40'h08_08_08_08_08;
            8'h2E: r = 40'h00_00_60_60_00;
            8'h2F: r = 40'h02_04_08_10_20;
            8'h30: r = 40'h3E_45_49_51_3E;
            8'h31: r = 40'h00_40_7F_42_00;
            8'h32: r = 40'h46_49_51_61_42;
            8'h33: r = 40'h31_4B_45_41_21;
            8'h34: r = 40'h10_7F_12_14_18;
            8'h35: r = 40'h39_45_45_45_27;
            8'h36: r = 40'h30_49_49_4A_3C;
            8'h37: r = 40'h03_05_09_71_01;
            8'h38: r = 40'h36_49_49_49_36;
            8'h39: r = 40'h1E_29_49_49_06;
            8'h3A: r = 40'h00_00_36_36_00;
            8'h3B: r = 40'h00_00_36_56_00;
            8'h3C: r = 40'h00_41_22_14_08;
            8'h3D: r = 40'h14_14_14_14_14;
            8'h3E: r = 40'h08_14_22_41_00;
            8'h3F: r = 40'h06_09_51_01_02;
            8'h40: r = 40'h3E_51_59_49_32;
            8'h41: r = 40'h7C_12_11_12_7C;
            8'h42: r = 40'h36_49_49_49_7F;
            8'h43: r = 40'h22_41_41_41_3E;
            8'h44: r = 40'h1C_22_41_41_7F;
            8'h45: r = 40'h41_49_49_49_7F;
            8'h46: r = 40'h01_09_09_09_7F;
            8'h47: r = 40'h7A_49_49_41_3E;
            8'h48: r = 40'h7F_08_08_08_7F;
            8'h49: r = 40'h00_41_7F_41_00;
            8'h4A: r = 40'h01_3F_41_40_20;
            8'h4B: r = 40'h41_22_14_08_7F;
            8'h4C: r = 40'h40_40_40_40_7F;
            8'h4D: r = 40'h7F_02_0C_02_7F;
            8'h4E: r = 40'h7F_10_08_04_7F;
            8'h4F: r = 40'h3E_41_41_41_3E;
            8'h50: r = 40'h06_09_09_09_7F;
            8'h51: r = 40'h5E_21_51_41_3E;
            8'h52: r = 40'h46_29_19_09_7F;
            8'h53: r = 40'h31_49_49_49_46;
            8'h54: r = 40'h01_01_7F_01_01;
            8'h55: r = 40'h3F_40_40_40_3F;
            8'h56: r = 40'h1F_20_40_20_1F;
            8'h57: r = 40'h3F_40_38_40_3F;
            8'h58: r = 40'h63_14_08_14_63;
            8'h59: r = 40'h07_08_70_08_07;
            default: r = 40'h00_00_00_00_00;
        endcase
        return r;
    endfunction

endpackage

[design/oled_text_character_generator.sv]
// Text character generator for a page-addressed OLED controller: each request word
// yields a run of command and display data words, one word per cycle at the output
// while m_axis_tready is high. A drawn character yields 6 words, or 13 when it wraps
// to the next page; a new line, return or cursor set yields 7. The byte sequencer
// sets the sustained rate; the front end takes a request every cycle while its job
// queue (QUEUE_DEPTH entries) has room. m_axis_tlast marks the final word of each request. Depends on otcg_pkg.
`include "oled_text_character_generator_macros.svh"

module oled_text_character_generator
    import otcg_pkg::*;
#(
    parameter int DISPLAY_COLUMNS = DEFAULT_COLUMNS,
    parameter int DISPLAY_PAGES   = DEFAULT_PAGES,
    parameter int QUEUE_DEPTH     = DEFAULT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_code[7:0], line[10:8], column[17:11]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // value[7:0]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast
);

    job_t    push_job;
    job_t    head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    otcg_front #(
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
        .DISPLAY_PAGES   (DISPLAY_PAGES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .push          (push),
        .job           (push_job)
    );

    otcg_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    otcg_back #(
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
        .DISPLAY_PAGES   (DISPLAY_PAGES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `OTCG_ASSERT_IMP(a_last_not_cmd, m_axis_tvalid && m_axis_tlast, m_axis_tuser != KIND_CMD, "last word is a command")
    `OTCG_ASSERT_IMP(a_open_zero, m_axis_tvalid && (m_axis_tuser == KIND_OPEN), m_axis_tdata == 8'h00, "open marker not zero")
    `OTCG_ASSERT_NXT(a_push_fills, s_axis_tvalid && s_axis_tready, !q_stat.empty, "accepted word lost from queue")

endmodule

[design/otcg_front.sv]
// Front end: accepts text requests, tracks the cursor, builds jobs.
// Depends on otcg_pkg.
module otcg_front
    import otcg_pkg::*;
#(
    parameter int DISPLAY_COLUMNS = DEFAULT_COLUMNS,
    parameter int DISPLAY_PAGES   = DEFAULT_PAGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_code[7:0], line[10:8], column[17:11]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    input  q_stat_t     q_stat,
    output logic        push,
    output job_t        job
);

    localparam int LINE_W = $clog2(DISPLAY_PAGES);
    localparam logic [4:0] PAGES_W5 = 5'(DISPLAY_PAGES);
    localparam logic [8:0] COLS_W9  = 9'(DISPLAY_COLUMNS);

    logic [LINE_W-1:0] line_reg, line_next;
    logic [7:0]        col_reg, col_next;
    logic [LINE_W-1:0] nl;
    logic              wrap;
    logic [7:0]        code;
    logic [2:0]        in_line;
    logic [6:0]        in_col;
    mode_t             mode;

    function automatic logic [LINE_W-1:0] line_mod(input logic [2:0] ln);
        logic [4:0] v;
        v = {2'b00, ln};
        for (int i = 0; i < 3; i++) begin
            if (v >= PAGES_W5)
            begin
                v = v - PAGES_W5;
            end
        end
        return v[LINE_W-1:0];
    endfunction

    function automatic logic [7:0] ext8(input logic [LINE_W-1:0] v);
        return {{(8 - LINE_W){1'b0}}, v};
    endfunction

    assign code    = s_axis_tdata[7:0];
    assign in_line = s_axis_tdata[10:8];
    assign in_col  = s_axis_tdata[17:11];
    assign mode    = mode_t'(s_axis_tuser);

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && s_axis_tready;

    assign nl   = (line_reg == LINE_W'(DISPLAY_PAGES - 1)) ? '0 : line_reg + 1'b1;
    assign wrap = ({1'b0, col_reg} + 9'd5) >= COLS_W9;

    always_comb
    begin
        line_next    = line_reg;
        col_next     = col_reg;
        job.cursor   = 1'b1;
        job.glyph    = 1'b0;
        job.col      = 8'h00;
        job.line_val = ext8(line_reg);
        job.bits     = font_row(code);
        case (mode)
            MODE_CHAR:
            begin
                job.glyph  = 1'b1;
                job.cursor = wrap;
                job.line_val = ext8(nl);
                if (wrap)
                begin
                    line_next = nl;
                    col_next  = 8'd6;
                end
                else
                begin
                    col_next = col_reg + 8'd6;
                end
            end
            MODE_NEWLINE:
            begin
                line_next    = nl;
                col_next     = 8'h00;
                job.line_val = ext8(nl);
            end
            MODE_HOME:
            begin
                col_next = 8'h00;
            end
            MODE_SET:
            begin
                line_next    = line_mod(in_line);
                col_next     = {1'b0, in_col};
                job.col      = {1'b0, in_col};
                job.line_val = ext8(line_mod(in_line));
            end
            default:
            begin
                line_next = line_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            col_reg  <= 8'h00;
        end
        else if (push)
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

[design/otcg_queue.sv]
// Small job queue between front end and byte sequencer.
// Depends on otcg_pkg.
module otcg_queue
    import otcg_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t q_stat
);

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    job_t              mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [ADDR_W-1:0] bump(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/otcg_back.sv]
// Byte sequencer: expands each job into command and data words.
// Depends on otcg_pkg; output register holds each word while the downstream stalls.
module otcg_back
    import otcg_pkg::*;
#(
    parameter int DISPLAY_COLUMNS = DEFAULT_COLUMNS,
    parameter int DISPLAY_PAGES   = DEFAULT_PAGES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // value[7:0]
    output logic [1:0] m_axis_tuser,   // kind[1:0]
    output logic       m_axis_tlast
);

    localparam logic [3:0] STEP_OPEN  = 4'd6;
    localparam logic [3:0] STEP_GLYPH = 4'd7;
    localparam logic [3:0] STEP_END   = 4'd12;
    localparam logic [7:0] LAST_COL   = 8'(DISPLAY_COLUMNS - 1);
    localparam logic [7:0] LAST_PAGE  = 8'(DISPLAY_PAGES - 1);

    logic       busy_reg;
    logic [3:0] step_reg;
    logic       out_valid_reg;
    logic [7:0] value_reg;
    kind_t      kind_reg;
    logic       last_reg;

    logic [3:0] step;
    logic [3:0] gidx;
    logic       load;
    logic       is_last;
    logic [7:0] value_next;
    kind_t      kind_next;

    assign step    = busy_reg ? step_reg : (head.cursor ? 4'd0 : STEP_GLYPH);
    assign load    = !q_stat.empty && (!out_valid_reg || m_axis_tready);
    assign is_last = ((step == STEP_OPEN) && !head.glyph) || (step == STEP_END);
    assign pop     = load && is_last;
    assign gidx    = step - STEP_GLYPH;

    always_comb
    begin
        kind_next  = KIND_CMD;
        value_next = 8'h00;
        case (step)
            4'd0: value_next = CMD_COL_ADDR;
            4'd1: value_next = head.col;
            4'd2: value_next = LAST_COL;
            4'd3: value_next = CMD_PAGE_ADDR;
            4'd4: value_next = head.line_val;
            4'd5: value_next = LAST_PAGE;
            STEP_OPEN: kind_next = KIND_OPEN;
            4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
            begin
                kind_next  = KIND_DATA;
                value_next = head.bits[8 * gidx[2:0] +: 8];
            end
            STEP_END:
            begin
                kind_next  = KIND_DATA;
                value_next = GLYPH_BLANK;
            end
            default: kind_next = KIND_CMD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            busy_reg      <= !is_last;
            step_reg      <= step + 4'd1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
            kind_reg  <= kind_next;
            last_reg  <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule

[dv/oled_byte_checker.sv]
`timescale 1ns / 100ps
// Checker for the OLED text character generator: watches both stream ports,
// predicts the command/data bytes for each request word and compares them in order.
// Depends on otcg_pkg.
module oled_byte_checker
    import otcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          mismatch_count,
    output int          bytes_outstanding
);

    localparam int COLUMNS    = DEFAULT_COLUMNS;
    localparam int PAGES      = DEFAULT_PAGES;
    localparam int FONT_FIRST = 'h20;
    localparam int FONT_SIZE  = 58;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } out_byte_t;

    // columns left to right, first column in the top byte
    logic [39:0] glyph_rom [0:FONT_SIZE-1] = '{
        40'h00_00_00_00_00, 40'h00_00_2F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
        40'h00_00_A0_60_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
        40'h32_49_59_51_3E, 40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
        40'h63_14_08_14_63, 40'h07_08_70_08_07
    };

    out_byte_t   expected_bytes [$];
    logic [2:0]  cursor_line;
    logic [7:0]  cursor_column;

    task automatic push_byte(input kind_t kind, input logic [7:0] value, input logic last);
        out_byte_t b;
        begin
            b.kind  = kind;
            b.value = value;
            b.last  = last;
            expected_bytes.push_back(b);
        end
    endtask

    task automatic emit_cursor_set(input logic [2:0] line, input logic [7:0] column,
                                   input logic ends_request);
        begin
            cursor_line   = line;
            cursor_column = column;
            push_byte(KIND_CMD, CMD_COL_ADDR, 1'b0);
            push_byte(KIND_CMD, column, 1'b0);
            push_byte(KIND_CMD, 8'(COLUMNS - 1), 1'b0);
            push_byte(KIND_CMD, CMD_PAGE_ADDR, 1'b0);
            push_byte(KIND_CMD, 8'(line), 1'b0);
            push_byte(KIND_CMD, 8'(PAGES - 1), 1'b0);
            push_byte(KIND_OPEN, 8'h00, ends_request);
        end
    endtask

    task automatic predict_request(input mode_t mode, input logic [7:0] code,
                                   input logic [2:0] line, input logic [6:0] column);
        logic [2:0]  next_line;
        logic [39:0] glyph;
        begin
            next_line = 3'((int'(cursor_line) + 1) % PAGES);
            case (mode)
                MODE_CHAR:
                begin
                    if (int'(cursor_column) + 5 >= COLUMNS)
                        emit_cursor_set(next_line, 8'h00, 1'b0);
                    glyph = 40'h0;
                    if (int'(code) >= FONT_FIRST && int'(code) < FONT_FIRST + FONT_SIZE)
                        glyph = glyph_rom[int'(code) - FONT_FIRST];
                    for (int i = 0; i < 5; i++)
                        push_byte(KIND_DATA, glyph[39 - 8 * i -: 8], 1'b0);
                    push_byte(KIND_DATA, GLYPH_BLANK, 1'b1);
                    cursor_column = cursor_column + 8'd6;
                end
                MODE_NEWLINE: emit_cursor_set(next_line, 8'h00, 1'b1);
                MODE_HOME:    emit_cursor_set(cursor_line, 8'h00, 1'b1);
                default:      emit_cursor_set(3'(int'(line) % PAGES), {1'b0, column}, 1'b1);
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_byte_t want;
        if (!rst_n)
        begin
            cursor_line       = 3'd0;
            cursor_column     = 8'd0;
            mismatch_count    = 0;
            bytes_outstanding = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_request(mode_t'(s_axis_tuser), s_axis_tdata[7:0],
                                s_axis_tdata[10:8], s_axis_tdata[17:11]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected word: kind %0d value 0x%02h last %0b",
                           m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata !== want.value)
                    begin
                        $error("value: expected 0x%02h, actual 0x%02h",
                               want.value, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
            bytes_outstanding = expected_bytes.size();
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the OLED text character generator testbench: clock, reset, request stimulus,
// random output stalls, watchdog and verdict. Depends on otcg_pkg and oled_byte_checker.
module tb_top;
    import otcg_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 98;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic [1:0]  s_axis_tuser  = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        steady        = 1'b0;
    int          mismatch_count;
    int          bytes_outstanding;

    always #6 clk = ~clk;

    oled_text_character_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    oled_byte_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .m_axis_tlast      (m_axis_tlast),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 34);

    task automatic send_request(input mode_t mode, input logic [7:0] code,
                                input logic [2:0] line, input logic [6:0] column,
                                input logic no_gaps);
        begin
            if (!no_gaps)
                while ($urandom_range(0, 99) < 34)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= mode;
            s_axis_tdata  <= {6'd0, column, line, code};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    task automatic send_random_request(input logic no_gaps);
        int          pick;
        mode_t       mode;
        logic [7:0]  code;
        logic [6:0]  column;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                mode = MODE_CHAR;
            else if (pick < 75)
                mode = MODE_NEWLINE;
            else if (pick < 83)
                mode = MODE_HOME;
            else
                mode = MODE_SET;
            // mostly printable glyphs, some arbitrary codes
            if ($urandom_range(0, 99) < 80)
                code = 8'($urandom_range('h20, 'h59));
            else
                code = 8'($urandom_range(0, 255));
            // bias cursor sets toward the right edge so wraps are frequent
            if ($urandom_range(0, 1) == 0)
                column = 7'($urandom_range(100, 127));
            else
                column = 7'($urandom_range(0, 127));
            send_request(mode, code, 3'($urandom_range(0, 7)), column, no_gaps);
        end
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_CHAR,    8'h41, 3'd0, 7'd0,   1'b0);
        send_request(MODE_CHAR,    8'h20, 3'd7, 7'd127, 1'b0);
        send_request(MODE_CHAR,    8'h59, 3'd0, 7'd0,   1'b0);
        send_request(MODE_CHAR,    8'h5A, 3'd0, 7'd0,   1'b0);
        send_request(MODE_CHAR,    8'h1F, 3'd0, 7'd0,   1'b0);
        send_request(MODE_CHAR,    8'h00, 3'd0, 7'd0,   1'b0);
        send_request(MODE_CHAR,    8'hFF, 3'd0, 7'd0,   1'b0);
        send_request(MODE_CHAR,    8'h7F, 3'd0, 7'd0,   1'b0);
        send_request(MODE_NEWLINE, 8'hFF, 3'd7, 7'd127, 1'b0);
        send_request(MODE_HOME,    8'hAA, 3'd5, 7'd85,  1'b0);
        // last column that still fits, then a wrap from the last page to page 0
        send_request(MODE_SET,     8'h00, 3'd7, 7'd122, 1'b0);
        send_request(MODE_CHAR,    8'h30, 3'd0, 7'd0,   1'b0);
        send_request(MODE_CHAR,    8'h31, 3'd0, 7'd0,   1'b0);
        // first column that no longer fits
        send_request(MODE_SET,     8'h00, 3'd3, 7'd123, 1'b0);
        send_request(MODE_CHAR,    8'h2C, 3'd0, 7'd0,   1'b0);
        // last column, then newline from the last page
        send_request(MODE_SET,     8'h55, 3'd7, 7'd127, 1'b0);
        send_request(MODE_NEWLINE, 8'h00, 3'd0, 7'd0,   1'b0);
        send_request(MODE_SET,     8'h55, 3'd7, 7'd127, 1'b0);
        send_request(MODE_CHAR,    8'h4D, 3'd0, 7'd0,   1'b0);
        send_request(MODE_SET,     8'h00, 3'd0, 7'd0,   1'b0);
        send_request(MODE_SET,     8'h00, 3'd5, 7'd64,  1'b0);
        send_request(MODE_HOME,    8'h00, 3'd0, 7'd0,   1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            steady <= (n >= 40 && n < 70);
            send_random_request(n >= 40 && n < 70);
        end
        s_axis_tvalid <= 1'b0;
        steady        <= 1'b0;
        @(posedge clk);

        while (bytes_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
